@@ hdl/toti_pkg.sv @@
// Package for the 2-opt tour improver: widths, opcodes, command/status types.
package toti_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int DIST_BITS_DEF    = 16;

  localparam int OP_W    = 3;
  localparam int IDX_W   = 6;
  localparam int VAL_W   = 22;
  localparam int VERT_W  = 6;
  localparam int LEN_W   = 24;
  localparam int TSIZE_W = 7;

  localparam logic [OP_W-1:0] OP_WR_DIST = 3'd0;
  localparam logic [OP_W-1:0] OP_WR_TOUR = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_LEN = 3'd2;
  localparam logic [OP_W-1:0] OP_IMPROVE = 3'd3;
  localparam logic [OP_W-1:0] OP_RD_TOUR = 3'd4;

  typedef enum logic [2:0] {TA_IM1, TA_I, TA_J, TA_SUCC, TA_OPA} tour_ra_e;
  typedef enum logic [1:0] {TW_OP, TW_LO, TW_HI} tour_wsel_e;
  typedef enum logic [2:0] {CAP_NONE, CAP_BEFORE, CAP_FIRST, CAP_LAST, CAP_AFTER,
                            CAP_TMP} cap_e;
  typedef enum logic [1:0] {MA_BL, MA_AF, MA_BF, MA_LA} mat_ra_e;
  typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB} acc_e;
  typedef enum logic [2:0] {CTR_NONE, CTR_INIT, CTR_NEXT_J, CTR_NEXT_I, CTR_SWAP} ctr_e;

  typedef struct packed {
    logic       in_load;
    logic       tour_re;
    tour_ra_e   tour_ra;
    logic       tour_we;
    tour_wsel_e tour_wsel;
    cap_e       cap;
    logic       mat_re;
    mat_ra_e    mat_ra;
    logic       mat_we;
    acc_e       acc;
    ctr_e       ctr;
    logic       len_set;
    logic       len_upd;
    logic       imp_set;
    logic       imp_clr;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            n_small;
    logic            i_last;
    logic            j_last;
    logic            neg;
    logic            lo_lt_hi;
  } status_t;

endpackage

@@ hdl/toti_if.sv @@
// Valid/ready channel interfaces for operation requests and results.
interface toti_in_if;
  import toti_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] index_a;
  logic [IDX_W-1:0] index_b;
  logic [VAL_W-1:0] value;
  modport source (output valid, opcode, index_a, index_b, value, input ready);
  modport sink (input valid, opcode, index_a, index_b, value, output ready);
endinterface

interface toti_out_if;
  import toti_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     improved;
  logic signed [LEN_W-1:0]  tour_length;
  logic [VERT_W-1:0]        vertex;
  modport source (output valid, improved, tour_length, vertex, input ready);
  modport sink (input valid, improved, tour_length, vertex, output ready);
endinterface

@@ hdl/toti_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module toti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ hdl/toti_ctrl.sv @@
// Controller FSM: sequences operations, the 2-opt scan and segment reversal.
module toti_ctrl
  import toti_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DEC  = 5'd1;
  localparam logic [4:0] S_R0   = 5'd2;
  localparam logic [4:0] S_R1   = 5'd3;
  localparam logic [4:0] S_R2   = 5'd4;
  localparam logic [4:0] S_R3   = 5'd5;
  localparam logic [4:0] S_R4   = 5'd6;
  localparam logic [4:0] S_M1   = 5'd7;
  localparam logic [4:0] S_M2   = 5'd8;
  localparam logic [4:0] S_M3   = 5'd9;
  localparam logic [4:0] S_M4   = 5'd10;
  localparam logic [4:0] S_EV   = 5'd11;
  localparam logic [4:0] S_RV0  = 5'd12;
  localparam logic [4:0] S_RV1  = 5'd13;
  localparam logic [4:0] S_RV2  = 5'd14;
  localparam logic [4:0] S_RV3  = 5'd15;
  localparam logic [4:0] S_FIN  = 5'd16;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        case (status_i.op)
          OP_WR_DIST: begin
            cmd_o.mat_we = 1'b1;
            state_d      = S_FIN;
          end
          OP_WR_TOUR: begin
            cmd_o.tour_we   = 1'b1;
            cmd_o.tour_wsel = TW_OP;
            state_d         = S_FIN;
          end
          OP_SET_LEN: begin
            cmd_o.len_set = 1'b1;
            state_d       = S_FIN;
          end
          OP_IMPROVE: begin
            cmd_o.imp_clr = 1'b1;
            cmd_o.ctr     = CTR_INIT;
            state_d       = status_i.n_small ? S_FIN : S_R0;
          end
          OP_RD_TOUR: begin
            cmd_o.tour_re = 1'b1;
            cmd_o.tour_ra = TA_OPA;
            state_d       = S_FIN;
          end
          default: state_d = S_IDLE;  // unknown opcode: no result
        endcase
      end
      S_R0: begin
        cmd_o.tour_re = 1'b1;
        cmd_o.tour_ra = TA_IM1;
        state_d       = S_R1;
      end
      S_R1: begin
        cmd_o.tour_re = 1'b1;
        cmd_o.tour_ra = TA_I;
        cmd_o.cap     = CAP_BEFORE;
        state_d       = S_R2;
      end
      S_R2: begin
        cmd_o.tour_re = 1'b1;
        cmd_o.tour_ra = TA_J;
        cmd_o.cap     = CAP_FIRST;
        state_d       = S_R3;
      end
      S_R3: begin
        cmd_o.tour_re = 1'b1;
        cmd_o.tour_ra = TA_SUCC;
        cmd_o.cap     = CAP_LAST;
        state_d       = S_R4;
      end
      S_R4: begin
        cmd_o.cap    = CAP_AFTER;
        cmd_o.mat_re = 1'b1;
        cmd_o.mat_ra = MA_BL;
        state_d      = S_M1;
      end
      S_M1: begin
        cmd_o.mat_re = 1'b1;
        cmd_o.mat_ra = MA_AF;
        cmd_o.acc    = ACC_LOAD;
        state_d      = S_M2;
      end
      S_M2: begin
        cmd_o.mat_re = 1'b1;
        cmd_o.mat_ra = MA_BF;
        cmd_o.acc    = ACC_ADD;
        state_d      = S_M3;
      end
      S_M3: begin
        cmd_o.mat_re = 1'b1;
        cmd_o.mat_ra = MA_LA;
        cmd_o.acc    = ACC_SUB;
        state_d      = S_M4;
      end
      S_M4: begin
        cmd_o.acc = ACC_SUB;
        state_d   = S_EV;
      end
      S_EV: begin
        if (status_i.neg) begin
          cmd_o.len_upd = 1'b1;
          cmd_o.imp_set = 1'b1;
          state_d       = S_RV0;
        end else if (!status_i.j_last) begin
          cmd_o.ctr = CTR_NEXT_J;
          state_d   = S_R0;
        end else if (!status_i.i_last) begin
          cmd_o.ctr = CTR_NEXT_I;
          state_d   = S_R0;
        end else begin
          state_d = S_FIN;
        end
      end
      // reversal reuses i/j as the low/high swap pointers
      S_RV0: begin
        if (status_i.lo_lt_hi) begin
          cmd_o.tour_re = 1'b1;
          cmd_o.tour_ra = TA_I;
          state_d       = S_RV1;
        end else begin
          state_d = S_FIN;
        end
      end
      S_RV1: begin
        cmd_o.tour_re = 1'b1;
        cmd_o.tour_ra = TA_J;
        cmd_o.cap     = CAP_TMP;
        state_d       = S_RV2;
      end
      S_RV2: begin
        cmd_o.tour_we   = 1'b1;
        cmd_o.tour_wsel = TW_LO;
        state_d         = S_RV3;
      end
      S_RV3: begin
        cmd_o.tour_we   = 1'b1;
        cmd_o.tour_wsel = TW_HI;
        cmd_o.ctr       = CTR_SWAP;
        state_d         = S_RV0;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

@@ hdl/toti_dp.sv @@
// Datapath: matrix and tour RAMs, scan pointers, length arithmetic, result regs.
module toti_dp
  import toti_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int DIST_BITS    = DIST_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic [TSIZE_W-1:0]      tour_size_i,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic [IDX_W-1:0]        index_a_i,
  input  logic [IDX_W-1:0]        index_b_i,
  input  logic [VAL_W-1:0]        value_i,
  output logic                    improved_o,
  output logic signed [LEN_W-1:0] tour_length_o,
  output logic [VERT_W-1:0]       vertex_o
);
  localparam int VBITS = $clog2(MAX_VERTICES);
  localparam int NBITS = $clog2(MAX_VERTICES + 1);
  localparam int MBITS = 2 * VBITS;
  localparam int AW    = DIST_BITS + 3;
  localparam int SW    = ((LEN_W > AW) ? LEN_W : AW) + 1;

  logic [OP_W-1:0]   op_q;
  logic [IDX_W-1:0]  a_q, b_q;
  logic [VAL_W-1:0]  val_q;
  logic [VERT_W-1:0] before_q, first_q, last_q, after_q, tmp_q;
  logic [VBITS-1:0]  i_q, j_q;
  logic signed [AW-1:0]    acc_q;
  logic signed [LEN_W-1:0] len_q;
  logic              imp_q, zero_q;
  logic              out_imp_q;
  logic signed [LEN_W-1:0] out_len_q;
  logic [VERT_W-1:0] out_vert_q;

  logic [NBITS-1:0]  n;
  logic              a_ok, b_ok, j_last;
  logic [VBITS-1:0]  succ;
  logic [VBITS-1:0]  tour_ra, tour_wa;
  logic [VERT_W-1:0] tour_wd, tour_rd;
  logic              tour_we;
  logic [VERT_W-1:0] mu, mv;
  logic [MBITS-1:0]  mat_ra, mat_wa;
  logic [DIST_BITS-1:0] mat_rd;
  logic              mat_we;
  logic signed [AW-1:0] dterm;
  logic signed [SW-1:0] sum;
  logic signed [LEN_W-1:0] len_sat;

  assign n      = (32'(tour_size_i) > MAX_VERTICES) ? NBITS'(MAX_VERTICES)
                                                    : NBITS'(tour_size_i);
  assign a_ok   = 32'(a_q) < MAX_VERTICES;
  assign b_ok   = 32'(b_q) < MAX_VERTICES;
  assign j_last = (32'(j_q) + 1) == 32'(n);
  assign succ   = j_last ? '0 : j_q + 1'b1;

  assign status_o.op       = op_q;
  assign status_o.n_small  = n < NBITS'(3);
  assign status_o.i_last   = (32'(i_q) + 2) == 32'(n);
  assign status_o.j_last   = j_last;
  assign status_o.neg      = acc_q[AW-1];
  assign status_o.lo_lt_hi = i_q < j_q;

  // tour store
  always_comb begin
    case (cmd_i.tour_ra)
      TA_IM1:  tour_ra = i_q - 1'b1;
      TA_I:    tour_ra = i_q;
      TA_J:    tour_ra = j_q;
      TA_SUCC: tour_ra = succ;
      TA_OPA:  tour_ra = VBITS'(a_q);
      default: tour_ra = i_q;
    endcase
    case (cmd_i.tour_wsel)
      TW_OP: begin
        tour_wa = VBITS'(a_q);
        tour_wd = VERT_W'(b_q);
      end
      TW_LO: begin
        tour_wa = i_q;
        tour_wd = tour_rd;
      end
      TW_HI: begin
        tour_wa = j_q;
        tour_wd = tmp_q;
      end
      default: begin
        tour_wa = i_q;
        tour_wd = tour_rd;
      end
    endcase
  end

  assign tour_we = cmd_i.tour_we && ((cmd_i.tour_wsel != TW_OP) || a_ok);

  toti_ram #(
    .WIDTH(VERT_W),
    .DEPTH(MAX_VERTICES)
  ) u_tour_ram (
    .clk_i  (clk_i),
    .we_i   (tour_we),
    .waddr_i(tour_wa),
    .wdata_i(tour_wd),
    .re_i   (cmd_i.tour_re),
    .raddr_i(tour_ra),
    .rdata_o(tour_rd)
  );

  // distance matrix
  always_comb begin
    case (cmd_i.mat_ra)
      MA_BL: begin
        mu = before_q;
        mv = last_q;
      end
      MA_AF: begin
        mu = after_q;
        mv = first_q;
      end
      MA_BF: begin
        mu = before_q;
        mv = first_q;
      end
      MA_LA: begin
        mu = last_q;
        mv = after_q;
      end
      default: begin
        mu = before_q;
        mv = last_q;
      end
    endcase
  end

  assign mat_ra = {VBITS'(mu), VBITS'(mv)};
  assign mat_wa = {VBITS'(a_q), VBITS'(b_q)};
  assign mat_we = cmd_i.mat_we && a_ok && b_ok;

  toti_ram #(
    .WIDTH(DIST_BITS),
    .DEPTH(MAX_VERTICES * MAX_VERTICES)
  ) u_mat_ram (
    .clk_i  (clk_i),
    .we_i   (mat_we),
    .waddr_i(mat_wa),
    .wdata_i(DIST_BITS'(val_q)),
    .re_i   (cmd_i.mat_re),
    .raddr_i(mat_ra),
    .rdata_o(mat_rd)
  );

  // out-of-range vertex reads as distance zero
  assign dterm = zero_q ? '0 : $signed({3'b000, mat_rd});

  assign sum = $signed({{(SW-LEN_W){len_q[LEN_W-1]}}, len_q})
             + $signed({{(SW-AW){acc_q[AW-1]}}, acc_q});

  always_comb begin
    if (sum[SW-1:LEN_W-1] == '0 || sum[SW-1:LEN_W-1] == '1) begin
      len_sat = sum[LEN_W-1:0];
    end else if (sum[SW-1]) begin
      len_sat = {1'b1, {(LEN_W-1){1'b0}}};
    end else begin
      len_sat = {1'b0, {(LEN_W-1){1'b1}}};
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q  <= opcode_i;
      a_q   <= index_a_i;
      b_q   <= index_b_i;
      val_q <= value_i;
    end
    case (cmd_i.cap)
      CAP_BEFORE: before_q <= tour_rd;
      CAP_FIRST:  first_q  <= tour_rd;
      CAP_LAST:   last_q   <= tour_rd;
      CAP_AFTER:  after_q  <= tour_rd;
      CAP_TMP:    tmp_q    <= tour_rd;
      default: ;
    endcase
    if (cmd_i.mat_re) begin
      zero_q <= (32'(mu) >= MAX_VERTICES) || (32'(mv) >= MAX_VERTICES);
    end
    case (cmd_i.acc)
      ACC_LOAD: acc_q <= dterm;
      ACC_ADD:  acc_q <= acc_q + dterm;
      ACC_SUB:  acc_q <= acc_q - dterm;
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_imp_q  <= (op_q == OP_IMPROVE) && imp_q;
      out_len_q  <= len_q;
      out_vert_q <= ((op_q == OP_RD_TOUR) && a_ok) ? tour_rd : '0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      imp_q <= 1'b0;
      i_q   <= '0;
      j_q   <= '0;
    end else begin
      if (cmd_i.len_set) begin
        len_q <= LEN_W'(val_q);
      end else if (cmd_i.len_upd) begin
        len_q <= len_sat;
      end
      if (cmd_i.imp_clr) begin
        imp_q <= 1'b0;
      end else if (cmd_i.imp_set) begin
        imp_q <= 1'b1;
      end
      case (cmd_i.ctr)
        CTR_INIT: begin
          i_q <= VBITS'(1);
          j_q <= VBITS'(2);
        end
        CTR_NEXT_J: j_q <= j_q + 1'b1;
        CTR_NEXT_I: begin
          i_q <= i_q + 1'b1;
          j_q <= i_q + VBITS'(2);
        end
        CTR_SWAP: begin
          i_q <= i_q + 1'b1;
          j_q <= j_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign improved_o    = out_imp_q;
  assign tour_length_o = out_len_q;
  assign vertex_o      = out_vert_q;
endmodule

@@ hdl/two_opt_tour_improve_top.sv @@
// Write/set ops and tour reads pass through decode and a finish state to the result register.
// Improve: each candidate pair scanned takes four tour reads and four matrix reads; a taken
// move updates the length, then swaps position pairs with two reads and two writes each;
// the scan is sequential, set by the single read port of the tour and matrix RAMs.
// One operation at a time; the next is taken once the result sits in the output reg.
// Reset (async, active low) clears tour size, length and control; RAMs are not cleared.
module two_opt_tour_improve_top
  import toti_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int DIST_BITS    = DIST_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TSIZE_W-1:0] cfg_wdata_i,
  toti_in_if.sink            in_i,
  toti_out_if.source         out_o
);
  cmd_t               cmd;
  status_t            status;
  logic [TSIZE_W-1:0] tour_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tour_size_q <= '0;
    end else if (cfg_we_i) begin
      tour_size_q <= cfg_wdata_i;
    end
  end

  toti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  toti_dp #(
    .MAX_VERTICES(MAX_VERTICES),
    .DIST_BITS   (DIST_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .tour_size_i  (tour_size_q),
    .opcode_i     (in_i.opcode),
    .index_a_i    (in_i.index_a),
    .index_b_i    (in_i.index_b),
    .value_i      (in_i.value),
    .improved_o   (out_o.improved),
    .tour_length_o(out_o.tour_length),
    .vertex_o     (out_o.vertex)
  );
endmodule
